// ===== sv/etg_pkg.sv =====
// Shared widths, constants, codes and types for the easing tween generator.
package etg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int DUR_W     = 16;
    localparam int EW        = FRAC_BITS + 8;
    localparam int PW        = VAL_W + EW;
    localparam int AW        = PW + 1;
    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam int CFG_IDX_W = 2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [EW-1:0]    ew_t;
    typedef logic signed [PW-1:0]    prod_t;
    typedef logic signed [AW-1:0]    acc_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DURATION = 2'd2;

    localparam logic [1:0] CURVE_LINEAR      = 2'd0;
    localparam logic [1:0] CURVE_BACK_IN     = 2'd1;
    localparam logic [1:0] CURVE_BACK_OUT    = 2'd2;
    localparam logic [1:0] CURVE_BACK_IN_OUT = 2'd3;

    localparam logic CMD_RETARGET = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [1:0]       RST_CURVE    = CURVE_BACK_OUT;
    localparam val_t             RST_VALUE    = 32'sd8847360;
    localparam logic [DUR_W-1:0] RST_DURATION = 16'd1000;

    localparam longint Q_ONE_L = longint'(1) << FRAC_BITS;
    localparam longint C1_L    = (170158 * Q_ONE_L + 50000) / 100000;
    localparam longint C2_L    = (25949095 * Q_ONE_L + 5000000) / 10000000;

    localparam ew_t Q_ONE  = ew_t'(Q_ONE_L);
    localparam ew_t Q_HALF = ew_t'(Q_ONE_L / 2);
    localparam ew_t Q_TWO  = ew_t'(2 * Q_ONE_L);
    localparam ew_t C1     = ew_t'(C1_L);
    localparam ew_t C2     = ew_t'(C2_L);
    localparam ew_t C1P    = ew_t'(C1_L + Q_ONE_L);
    localparam ew_t C2P    = ew_t'(C2_L + Q_ONE_L);

endpackage

// ===== sv/etg_div.sv =====
// Shift-subtract divider giving (elapsed << FRAC_BITS) / span, one quotient bit per cycle.
module etg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [etg_pkg::DUR_W-1:0]     elapsed,
    input  logic [etg_pkg::DUR_W-1:0]     span,
    output logic                          done,
    output logic [etg_pkg::FRAC_BITS-1:0] quotient
);

    logic                          busy_reg, busy_next;
    logic [etg_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [etg_pkg::DUR_W-1:0]     rem_reg, rem_next;
    logic [etg_pkg::FRAC_BITS-1:0] q_reg, q_next;
    logic [etg_pkg::DUR_W:0]       shifted;
    logic [etg_pkg::DUR_W:0]       diff;

    assign shifted  = {rem_reg, 1'b0};
    assign diff     = shifted - {1'b0, span};
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = etg_pkg::CNT_W'(etg_pkg::FRAC_BITS - 1);
            rem_next  = elapsed;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, span})
            begin
                rem_next = diff[etg_pkg::DUR_W-1:0];
                q_next   = {q_reg[etg_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[etg_pkg::DUR_W-1:0];
                q_next   = {q_reg[etg_pkg::FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

endmodule

// ===== sv/etg_mul.sv =====
// Shared signed multiplier with registered product.
module etg_mul (
    input  logic                 clk,
    input  etg_pkg::val_t        a,
    input  etg_pkg::ew_t         b,
    output etg_pkg::prod_t       prod
);

    etg_pkg::prod_t prod_reg, prod_next;

    assign prod_next = etg_pkg::prod_t'(a) * etg_pkg::prod_t'(b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== sv/easing_tween_generator.sv =====
// Top level: tween state, easing sequencer and result register of the easing tween generator.
//
// Usage:
//   Input items (command, time_ms, target_value, new_duration) transfer when in_valid is
//   high and in_stall is low. in_stall is high while an item is in work.
//   A retarget updates the tween and returns the present value with settled low.
//   A tick returns the eased value in Q16.16; at or past the end it returns the target
//   with settled high.
//   Results (current_value, settled) transfer when out_valid is high and out_stall low.
//   A retarget or a finished tick goes straight to the output state; a tick inside
//   the tween runs the 16-step shift-subtract divider and then the single shared
//   multiplier, used up to six times (twice for linear, five times for back-in and
//   back-out, six times for back-in-out). The next item is taken the cycle after the
//   result is loaded.
//   A finished result waits in the output register; while the receiver stalls, one more
//   item may be accepted and is held just before its result is loaded.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the user
//   must make them only while idle, as the block does not enforce it. Reset loads curve
//   back-out, the default value and a 1000 ms span, and leaves out_valid low.
module easing_tween_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [etg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [etg_pkg::VAL_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [etg_pkg::VAL_W-1:0]        time_ms,
    input  etg_pkg::val_t                    target_value,
    input  logic [etg_pkg::DUR_W-1:0]        new_duration,
    output logic                             out_valid,
    input  logic                             out_stall,
    output etg_pkg::val_t                    current_value,
    output logic                             settled
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_MSQ   = 4'd3;
    localparam logic [3:0] S_MLIN  = 4'd4;
    localparam logic [3:0] S_RLIN  = 4'd5;
    localparam logic [3:0] S_MCUB  = 4'd6;
    localparam logic [3:0] S_RCUB  = 4'd7;
    localparam logic [3:0] S_MHALF = 4'd8;
    localparam logic [3:0] S_RHALF = 4'd9;
    localparam logic [3:0] S_MIX1  = 4'd10;
    localparam logic [3:0] S_MIX2  = 4'd11;
    localparam logic [3:0] S_SUM   = 4'd12;
    localparam logic [3:0] S_ROUND = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam etg_pkg::val_t VAL_MAX = {1'b0, {(etg_pkg::VAL_W-1){1'b1}}};
    localparam etg_pkg::val_t VAL_MIN = {1'b1, {(etg_pkg::VAL_W-1){1'b0}}};

    function automatic etg_pkg::ew_t round_q(input etg_pkg::prod_t p);
        etg_pkg::prod_t s;
        s = (p + etg_pkg::prod_t'(etg_pkg::Q_HALF)) >>> etg_pkg::FRAC_BITS;
        return etg_pkg::ew_t'(s);
    endfunction

    logic [3:0]                    state_reg, state_next;
    logic [1:0]                    curve_reg, curve_next;
    etg_pkg::val_t                 start_val_reg, start_val_next;
    etg_pkg::val_t                 end_val_reg, end_val_next;
    etg_pkg::val_t                 present_reg, present_next;
    logic [etg_pkg::VAL_W-1:0]     start_time_reg, start_time_next;
    logic [etg_pkg::DUR_W-1:0]     span_reg, span_next;
    logic                          done_flag_reg, done_flag_next;
    logic                          out_valid_reg, out_valid_next;
    etg_pkg::val_t                 out_value_reg, out_value_next;
    logic                          out_settled_reg, out_settled_next;

    etg_pkg::ew_t                  x_reg, x_next;
    logic                          k2_reg, k2_next;
    logic                          neg_reg, neg_next;
    logic                          half_reg, half_next;
    etg_pkg::ew_t                  post_reg, post_next;
    etg_pkg::ew_t                  p1_reg, p1_next;
    etg_pkg::ew_t                  p2_reg, p2_next;
    etg_pkg::ew_t                  e_reg, e_next;
    etg_pkg::acc_t                 acc_reg, acc_next;

    logic [etg_pkg::VAL_W-1:0]     elapsed;
    logic                          div_start;
    logic                          div_done;
    logic [etg_pkg::FRAC_BITS-1:0] div_q;
    etg_pkg::val_t                 mul_a;
    etg_pkg::ew_t                  mul_b;
    etg_pkg::prod_t                prod;
    etg_pkg::ew_t                  t_ext;
    etg_pkg::ew_t                  s_ext;
    etg_pkg::ew_t                  k_sel;
    etg_pkg::ew_t                  rq;
    etg_pkg::acc_t                 acc_sh;

    etg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (elapsed[etg_pkg::DUR_W-1:0]),
        .span     (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    etg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign elapsed       = time_ms - start_time_reg;
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign current_value = out_value_reg;
    assign settled       = out_settled_reg;

    assign t_ext  = etg_pkg::ew_t'(div_q);
    assign s_ext  = t_ext <<< 1;
    assign k_sel  = k2_reg ? etg_pkg::C2 : etg_pkg::C1;
    assign rq     = round_q(prod);
    assign acc_sh = (acc_reg + etg_pkg::acc_t'(etg_pkg::Q_HALF)) >>> etg_pkg::FRAC_BITS;

    always_comb
    begin
        state_next       = state_reg;
        curve_next       = curve_reg;
        start_val_next   = start_val_reg;
        end_val_next     = end_val_reg;
        present_next     = present_reg;
        start_time_next  = start_time_reg;
        span_next        = span_reg;
        done_flag_next   = done_flag_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_settled_next = out_settled_reg;
        x_next           = x_reg;
        k2_next          = k2_reg;
        neg_next         = neg_reg;
        half_next        = half_reg;
        post_next        = post_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        e_next           = e_reg;
        acc_next         = acc_reg;
        div_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    done_flag_next = 1'b0;
                    if (command == etg_pkg::CMD_RETARGET)
                    begin
                        if (target_value != end_val_reg)
                        begin
                            if (new_duration != '0)
                            begin
                                span_next = new_duration;
                            end
                            start_val_next  = present_reg;
                            end_val_next    = target_value;
                            start_time_next = time_ms;
                        end
                        state_next = S_OUT;
                    end
                    else if (elapsed >= etg_pkg::VAL_W'(span_reg))
                    begin
                        present_next   = end_val_reg;
                        done_flag_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                k2_next   = 1'b0;
                half_next = 1'b0;
                state_next = S_MSQ;
                case (curve_reg)
                    etg_pkg::CURVE_LINEAR:
                    begin
                        e_next     = t_ext;
                        state_next = S_MIX1;
                    end
                    etg_pkg::CURVE_BACK_IN:
                    begin
                        x_next    = t_ext;
                        neg_next  = 1'b1;
                        post_next = '0;
                    end
                    etg_pkg::CURVE_BACK_OUT:
                    begin
                        x_next    = t_ext - etg_pkg::Q_ONE;
                        neg_next  = 1'b0;
                        post_next = etg_pkg::Q_ONE;
                    end
                    default:
                    begin
                        k2_next   = 1'b1;
                        half_next = 1'b1;
                        if (s_ext < etg_pkg::Q_ONE)
                        begin
                            x_next    = s_ext;
                            neg_next  = 1'b1;
                            post_next = '0;
                        end
                        else
                        begin
                            x_next    = s_ext - etg_pkg::Q_TWO;
                            neg_next  = 1'b0;
                            post_next = etg_pkg::Q_TWO;
                        end
                    end
                endcase
            end
            S_MSQ:
            begin
                mul_a      = etg_pkg::val_t'(x_reg);
                mul_b      = x_reg;
                state_next = S_MLIN;
            end
            S_MLIN:
            begin
                p1_next    = rq;
                mul_a      = etg_pkg::val_t'(k2_reg ? etg_pkg::C2P : etg_pkg::C1P);
                mul_b      = x_reg;
                state_next = S_RLIN;
            end
            S_RLIN:
            begin
                p2_next    = neg_reg ? (rq - k_sel) : (rq + k_sel);
                state_next = S_MCUB;
            end
            S_MCUB:
            begin
                mul_a      = etg_pkg::val_t'(p1_reg);
                mul_b      = p2_reg;
                state_next = S_RCUB;
            end
            S_RCUB:
            begin
                e_next     = rq + post_reg;
                state_next = half_reg ? S_MHALF : S_MIX1;
            end
            S_MHALF:
            begin
                mul_a      = etg_pkg::val_t'(e_reg);
                mul_b      = etg_pkg::Q_HALF;
                state_next = S_RHALF;
            end
            S_RHALF:
            begin
                e_next     = rq;
                state_next = S_MIX1;
            end
            S_MIX1:
            begin
                mul_a      = start_val_reg;
                mul_b      = etg_pkg::Q_ONE - e_reg;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                acc_next   = etg_pkg::acc_t'(prod);
                mul_a      = end_val_reg;
                mul_b      = e_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next   = acc_reg + etg_pkg::acc_t'(prod);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (acc_sh > etg_pkg::acc_t'(VAL_MAX))
                begin
                    present_next = VAL_MAX;
                end
                else if (acc_sh < etg_pkg::acc_t'(VAL_MIN))
                begin
                    present_next = VAL_MIN;
                end
                else
                begin
                    present_next = etg_pkg::val_t'(acc_sh);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = present_reg;
                    out_settled_next = done_flag_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            unique case (cfg_index)
                etg_pkg::CFG_CURVE_MODE:
                begin
                    curve_next = cfg_data[1:0];
                end
                etg_pkg::CFG_INITIAL_VALUE:
                begin
                    start_val_next = etg_pkg::val_t'(cfg_data);
                    end_val_next   = etg_pkg::val_t'(cfg_data);
                    present_next   = etg_pkg::val_t'(cfg_data);
                end
                etg_pkg::CFG_INITIAL_DURATION:
                begin
                    span_next = cfg_data[etg_pkg::DUR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            curve_reg       <= etg_pkg::RST_CURVE;
            start_val_reg   <= etg_pkg::RST_VALUE;
            end_val_reg     <= etg_pkg::RST_VALUE;
            present_reg     <= etg_pkg::RST_VALUE;
            start_time_reg  <= '0;
            span_reg        <= etg_pkg::RST_DURATION;
            done_flag_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            curve_reg       <= curve_next;
            start_val_reg   <= start_val_next;
            end_val_reg     <= end_val_next;
            present_reg     <= present_next;
            start_time_reg  <= start_time_next;
            span_reg        <= span_next;
            done_flag_reg   <= done_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        out_settled_reg <= out_settled_next;
        x_reg           <= x_next;
        k2_reg          <= k2_next;
        neg_reg         <= neg_next;
        half_reg        <= half_next;
        post_reg        <= post_next;
        p1_reg          <= p1_next;
        p2_reg          <= p2_next;
        e_reg           <= e_next;
        acc_reg         <= acc_next;
    end

endmodule
